// ----- hdl/necir_pkg.sv -----
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared types and constants for the symbol classifier, queue and frame logic.
// ----------------------------------------------------------------------------
package necir_pkg;

    // Widths of the symbol fields and of the configuration port.
    localparam int DUR_W   = 15;
    localparam int MARGIN_W = 10;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W  = 16;

    // Frame lengths and symbol positions.
    localparam logic [IDX_W-1:0] COUNT_MAX    = 6'd63;
    localparam logic [IDX_W-1:0] LAST_FULL    = 6'd33;  // index of symbol 34
    localparam logic [IDX_W-1:0] LAST_REPEAT  = 6'd1;   // index of symbol 2
    localparam logic [IDX_W-1:0] LAST_ADDRESS = 6'd16;
    localparam logic [IDX_W-1:0] LAST_DATA    = 6'd32;

    // Queue between classifier and frame logic.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MARGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE     = 3'd5;

    // Reported frame status.
    typedef enum logic [1:0] {
        ST_DECODED  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_REPEAT   = 2'd2
    } t_frame_status;

    // One classified symbol, as handed from the classifier to the frame logic.
    typedef struct packed {
        logic [IDX_W-1:0] idx;      // position of the symbol in its frame
        logic             bit_val;  // data bit value for data symbols
        logic             bad;      // timing did not match the expected symbol
        logic             last;     // final symbol of the frame
    } t_sym_cmd;

endpackage

// ----- hdl/nec_ir_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// NEC IR frame decoder top level
// Decodes NEC remote frames from a stream of captured mark/space symbols.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one IR symbol per request: mark and space
//   durations in microseconds, with tlast on the final symbol of a frame.
//   The master stream carries one result per 34-symbol frame (decoded or
//   rejected) and per 2-symbol repeat frame; other lengths give no result.
//   A classifier checks symbol timing and tracks the symbol position, a
//   four-entry request queue decouples it from the frame logic, which
//   collects the bits and drives a registered result output.
//   Throughput is one symbol per cycle while the queue has room. With the
//   queue empty and the output register free, a frame's last symbol is
//   written into the queue when it is accepted and then moves into the
//   output register, which raises o_m_tvalid.
//   When the receiver stalls, the result is held, the queue fills, and
//   o_s_tready drops once all four queue entries are taken.
//   The user must write timing registers only while the block is idle; no check is made.
//   Reset restores the default NEC timings, clears the frame in progress
//   and the saved address and command, and empties the queue.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top
    import necir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data,
    // Symbol stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // [14:0] mark_duration, [29:15] space_duration
    input  logic                 i_s_tlast,   // frame_last
    // Result stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata,   // [15:0] ir_address, [31:16] ir_command
    output logic [7:0]           o_m_tuser    // [1:0] frame_status
);

    logic          front_push;
    t_sym_cmd      front_cmd;
    logic          q_full;
    logic          q_valid;
    t_sym_cmd      q_cmd;
    logic          back_pop;
    t_frame_status status;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] command;

    necir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_mark      (i_s_tdata[14:0]),
        .i_space     (i_s_tdata[29:15]),
        .i_last      (i_s_tlast),
        .i_q_full    (q_full),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    necir_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    necir_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (back_pop),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_status  (status),
        .o_address (address),
        .o_command (command)
    );

    // Pack the result fields onto the stream.
    always_comb begin
        o_m_tdata = {command, address};
        o_m_tuser = {6'd0, status};
    end

endmodule

// ----- hdl/necir_front.sv -----
// ----------------------------------------------------------------------------
// NEC IR symbol classifier
// Holds the timing registers and the symbol position, and turns each accepted
// symbol into a classified request for the frame logic.
// ----------------------------------------------------------------------------
module necir_front
    import necir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DUR_W-1:0]     i_mark,
    input  logic [DUR_W-1:0]     i_space,
    input  logic                 i_last,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_sym_cmd             o_cmd
);

    logic [MARGIN_W-1:0] r_margin;
    logic [DUR_W-1:0]    r_leader_mark;
    logic [DUR_W-1:0]    r_leader_space;
    logic [DUR_W-1:0]    r_bit_mark;
    logic [DUR_W-1:0]    r_zero_space;
    logic [DUR_W-1:0]    r_one_space;
    logic [IDX_W-1:0]    r_count;
    logic [IDX_W-1:0]    n_count;
    logic                lm_ok, ls_ok, bm_ok, zs_ok, os_ok, one_ok, zero_ok;

    // Strict window test without wrap: |dur - nom| < margin.
    function automatic logic near_nominal(input logic [DUR_W-1:0] dur,
                                          input logic [DUR_W-1:0] nom,
                                          input logic [MARGIN_W-1:0] margin);
        logic [DUR_W:0] hi;
        logic [DUR_W:0] lo;
        hi = {1'b0, nom} + {{(DUR_W+1-MARGIN_W){1'b0}}, margin};
        lo = {1'b0, dur} + {{(DUR_W+1-MARGIN_W){1'b0}}, margin};
        return ({1'b0, dur} < hi) && (lo > {1'b0, nom});
    endfunction

    // Timing registers; the user must write them only while the block is idle (not checked).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin       <= 10'd200;
            r_leader_mark  <= 15'd9000;
            r_leader_space <= 15'd4500;
            r_bit_mark     <= 15'd560;
            r_zero_space   <= 15'd560;
            r_one_space    <= 15'd1690;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DECODE_MARGIN: r_margin       <= i_cfg_data[MARGIN_W-1:0];
                REG_LEADER_MARK:   r_leader_mark  <= i_cfg_data;
                REG_LEADER_SPACE:  r_leader_space <= i_cfg_data;
                REG_BIT_MARK:      r_bit_mark     <= i_cfg_data;
                REG_ZERO_SPACE:    r_zero_space   <= i_cfg_data;
                REG_ONE_SPACE:     r_one_space    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Timing matches for the current symbol.
    always_comb begin
        lm_ok   = near_nominal(i_mark,  r_leader_mark,  r_margin);
        ls_ok   = near_nominal(i_space, r_leader_space, r_margin);
        bm_ok   = near_nominal(i_mark,  r_bit_mark,     r_margin);
        zs_ok   = near_nominal(i_space, r_zero_space,   r_margin);
        os_ok   = near_nominal(i_space, r_one_space,    r_margin);
        one_ok  = bm_ok && os_ok;
        zero_ok = bm_ok && zs_ok;
    end

    // Classified request; a one is tested before a zero.
    always_comb begin
        o_ready       = !i_q_full;
        o_push        = i_valid && !i_q_full;
        o_cmd.idx     = r_count;
        o_cmd.last    = i_last;
        o_cmd.bit_val = 1'b0;
        o_cmd.bad     = 1'b0;
        if (r_count == '0) begin
            o_cmd.bad = !(lm_ok && ls_ok);
        end else if (r_count <= LAST_DATA) begin
            o_cmd.bit_val = one_ok;
            o_cmd.bad     = !one_ok && !zero_ok;
        end
    end

    // Symbol position, saturating, cleared at the end of each frame.
    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/necir_fifo.sv -----
// ----------------------------------------------------------------------------
// NEC IR request queue
// Short queue of classified symbols between the classifier and frame logic.
// ----------------------------------------------------------------------------
module necir_fifo
    import necir_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_sym_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_sym_cmd o_cmd
);

    t_sym_cmd           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    always_comb begin
        o_full  = (r_count == FIFO_DEPTH[FIFO_AW:0]);
        o_valid = (r_count != '0);
        o_cmd   = r_mem[r_rd_ptr];
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("request queue read while empty");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_DEPTH[FIFO_AW:0])
        else $error("request queue level out of range");
`endif

endmodule

// ----- hdl/necir_back.sv -----
// ----------------------------------------------------------------------------
// NEC IR frame logic
// Collects address and command bits, tracks frame validity and drives the
// registered result output.
// ----------------------------------------------------------------------------
module necir_back
    import necir_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_sym_cmd          i_cmd,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output t_frame_status     o_status,
    output logic [WORD_W-1:0] o_address,
    output logic [WORD_W-1:0] o_command
);

    logic                r_good, n_good;
    logic [WORD_W-1:0]   r_addr_sh, n_addr_sh;
    logic [WORD_W-1:0]   r_cmd_sh, n_cmd_sh;
    logic [WORD_W-1:0]   r_saved_addr, n_saved_addr;
    logic [WORD_W-1:0]   r_saved_cmd, n_saved_cmd;
    logic                r_out_valid, n_out_valid;
    t_frame_status       r_status, n_status;
    logic [WORD_W-1:0]   r_out_addr, n_out_addr;
    logic [WORD_W-1:0]   r_out_cmd, n_out_cmd;
    logic                produce;
    logic                good_sym;

    // A request that makes a result waits until the output register is free.
    always_comb begin
        produce = i_cmd.last && ((i_cmd.idx == LAST_FULL) || (i_cmd.idx == LAST_REPEAT));
        o_pop   = i_valid && (!produce || !r_out_valid || i_m_ready);
    end

    // Per-symbol frame update and result selection.
    always_comb begin
        n_good       = r_good;
        n_addr_sh    = r_addr_sh;
        n_cmd_sh     = r_cmd_sh;
        n_saved_addr = r_saved_addr;
        n_saved_cmd  = r_saved_cmd;
        n_status     = r_status;
        n_out_addr   = r_out_addr;
        n_out_cmd    = r_out_cmd;
        n_out_valid  = r_out_valid && !i_m_ready;
        good_sym     = r_good;
        if (o_pop) begin
            if (i_cmd.idx <= LAST_DATA) begin
                good_sym = r_good && !i_cmd.bad;
                n_good   = good_sym;
            end
            if ((i_cmd.idx != '0) && (i_cmd.idx <= LAST_ADDRESS)) begin
                n_addr_sh = {i_cmd.bit_val, r_addr_sh[WORD_W-1:1]};
            end else if ((i_cmd.idx > LAST_ADDRESS) && (i_cmd.idx <= LAST_DATA)) begin
                n_cmd_sh = {i_cmd.bit_val, r_cmd_sh[WORD_W-1:1]};
            end
            if (i_cmd.last) begin
                if (i_cmd.idx == LAST_FULL) begin
                    n_out_valid = 1'b1;
                    if (good_sym) begin
                        n_saved_addr = n_addr_sh;
                        n_saved_cmd  = n_cmd_sh;
                        n_status     = ST_DECODED;
                    end else begin
                        n_status     = ST_REJECTED;
                    end
                    n_out_addr = n_saved_addr;
                    n_out_cmd  = n_saved_cmd;
                end else if (i_cmd.idx == LAST_REPEAT) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_REPEAT;
                    n_out_addr  = '0;
                    n_out_cmd   = '0;
                end
                // Every frame end starts a fresh frame.
                n_good    = 1'b1;
                n_addr_sh = '0;
                n_cmd_sh  = '0;
            end
        end
    end

    // Frame state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good       <= 1'b1;
            r_addr_sh    <= '0;
            r_cmd_sh     <= '0;
            r_saved_addr <= '0;
            r_saved_cmd  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_good       <= n_good;
            r_addr_sh    <= n_addr_sh;
            r_cmd_sh     <= n_cmd_sh;
            r_saved_addr <= n_saved_addr;
            r_saved_cmd  <= n_saved_cmd;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_addr <= n_out_addr;
        r_out_cmd  <= n_out_cmd;
    end

    always_comb begin
        o_m_valid = r_out_valid;
        o_status  = r_status;
        o_address = r_out_addr;
        o_command = r_out_cmd;
    end

`ifndef SYNTHESIS
    a_repeat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_REPEAT)) |-> ((r_out_addr == '0) && (r_out_cmd == '0)))
        else $error("repeat result carries nonzero data");
    a_decoded_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_DECODED))
            |-> ((r_out_addr == r_saved_addr) && (r_out_cmd == r_saved_cmd)))
        else $error("decoded result differs from saved values");
    a_pop_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && produce) |-> (!r_out_valid || i_m_ready))
        else $error("result register overwritten while occupied");
`endif

endmodule
